[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands. Synthesis builds define SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/rbma_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbma_pkg
// Types and constants shared by the moving average block.
// ----------------------------------------------------------------------------
package rbma_pkg;

    // Default ring depth.
    localparam int MAX_WINDOW_DEF = 16;

    // Fixed field widths.
    localparam int SAMPLE_W = 32;
    localparam int CNT_W    = 5;

    // Window length after reset.
    localparam int WIN_RESET = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ADD,
        ST_START,
        ST_WAIT
    } rbma_state_t;

    // Divider status seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } rbma_div_status_t;

    // Sequencer controls for the datapath.
    typedef struct packed {
        logic in_ready;
        logic cfg_ready;
        logic ring_rd;
        logic ring_wr;
        logic div_start;
        logic load_out;
    } rbma_ctrl_t;

endpackage

[rtl/rbma_ring.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbma_ring
// Sample ring storage: one shared port, synchronous write, registered read.
// ----------------------------------------------------------------------------
module rbma_ring #(
    parameter int DEPTH  = rbma_pkg::MAX_WINDOW_DEF,
    parameter int ADDR_W = 4,
    parameter int DATA_W = rbma_pkg::SAMPLE_W
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wr_data,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/rbma_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbma_divider
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module rbma_divider #(
    parameter int SUM_W = 36,
    parameter int CNT_W = rbma_pkg::CNT_W,
    parameter int Q_W   = rbma_pkg::SAMPLE_W
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [SUM_W-1:0]    dividend,
    input  logic        [CNT_W-1:0]    divisor,
    output rbma_pkg::rbma_div_status_t status,
    output logic signed [Q_W-1:0]      quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  den_reg;
    logic              neg_reg;

    logic [SUM_W-1:0]  dvd_mag;
    logic [CNT_W:0]    rem_shift;
    logic [CNT_W:0]    rem_diff;
    logic              fits;
    logic [Q_W-1:0]    q_mag;

    always_comb
    begin
        dvd_mag   = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
        rem_shift = {rem_reg, quo_reg[SUM_W-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};
        fits      = rem_shift >= {1'b0, den_reg};
        q_mag     = quo_reg[Q_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(SUM_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dvd_mag;
            rem_reg <= '0;
            den_reg <= divisor;
            neg_reg <= dividend[SUM_W-1];
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            rem_reg <= fits ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = neg_reg ? (~q_mag + 1'b1) : q_mag;

endmodule

[rtl/ring_buffer_moving_average_top.sv]
`timescale 1ns / 1ps
// An accepted sample goes through READ, ADD, START and WAIT before its mean is registered.
// The next sample is taken only after the mean was loaded; the divider gives one bit per cycle.
// The ring read, the running-sum update and the divide run strictly one sample at a time.
// Reset (rst_n, asynchronous, active low) sets the window to 16 and clears slot, count and sum.
// The sample ring is not cleared; read data is used only once its entry was written.
// ----------------------------------------------------------------------------
// ring_buffer_moving_average_top
// Boxcar moving average over the most recent samples held in a ring memory.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ring_buffer_moving_average_top #(
    parameter int MAX_WINDOW = rbma_pkg::MAX_WINDOW_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Sample channel.
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [rbma_pkg::SAMPLE_W-1:0] sample,
    // Result channel.
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [rbma_pkg::SAMPLE_W-1:0] mean_value,
    output logic        [rbma_pkg::CNT_W-1:0]    held_count,
    // Window length register write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic        [rbma_pkg::CNT_W-1:0]    window_length
);

    localparam int SAMPLE_W = rbma_pkg::SAMPLE_W;
    localparam int CNT_W    = rbma_pkg::CNT_W;

    // The window register cannot exceed what its field can express.
    localparam int CNT_MAX  = (1 << CNT_W) - 1;
    localparam int MAX_EFF  = (MAX_WINDOW < CNT_MAX) ? MAX_WINDOW : CNT_MAX;
    localparam int WIN_RST  = (rbma_pkg::WIN_RESET > MAX_EFF) ? MAX_EFF : rbma_pkg::WIN_RESET;

    // Ring addressing; the slot never reaches the window length.
    localparam int IDX_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SLOT_W   = (IDX_W < CNT_W) ? IDX_W : CNT_W;

    // A sum of MAX_EFF samples fits exactly in this many bits.
    localparam int SUM_W    = SAMPLE_W + $clog2(MAX_EFF);

    rbma_pkg::rbma_state_t      state_reg;
    rbma_pkg::rbma_state_t      state_next;
    rbma_pkg::rbma_ctrl_t       ctrl;
    rbma_pkg::rbma_div_status_t div_status;

    logic        [CNT_W-1:0]    window_reg;
    logic        [CNT_W-1:0]    window_next;
    logic        [SLOT_W-1:0]   slot_reg;
    logic        [SLOT_W-1:0]   slot_next;
    logic        [CNT_W-1:0]    filled_reg;
    logic signed [SUM_W-1:0]    total_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W:0]   delta_reg;
    logic signed [SAMPLE_W:0]   delta_next;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] mean_value_reg;
    logic        [CNT_W-1:0]    held_count_reg;

    logic                       full;
    logic                       out_free;
    logic        [SLOT_W:0]     slot_inc;
    logic signed [SAMPLE_W-1:0] oldest;
    logic signed [SAMPLE_W-1:0] ring_rd_data;
    logic signed [SAMPLE_W-1:0] quotient;

    // ------------------------------------------------------------------------
    // Sequencer. A sample is taken in IDLE, where the ring entry at the write
    // slot is also read. The following cycle sees the read data, forms the
    // change to the running sum and overwrites the same entry with the new
    // sample. Because the next sample is not accepted until this one has left
    // the divider, a read and a write to the same entry never overlap.
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rbma_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rbma_pkg::ST_READ;
                end
            end
            rbma_pkg::ST_READ:  state_next = rbma_pkg::ST_ADD;
            rbma_pkg::ST_ADD:   state_next = rbma_pkg::ST_START;
            rbma_pkg::ST_START: state_next = rbma_pkg::ST_WAIT;
            rbma_pkg::ST_WAIT:
            begin
                if (div_status.done && out_free)
                begin
                    state_next = rbma_pkg::ST_IDLE;
                end
            end
            default:            state_next = rbma_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            rbma_pkg::ST_IDLE:
            begin
                ctrl.in_ready  = 1'b1;
                ctrl.cfg_ready = 1'b1;
                ctrl.ring_rd   = in_valid;
            end
            rbma_pkg::ST_READ:  ctrl.ring_wr   = 1'b1;
            rbma_pkg::ST_ADD:   ctrl = '0;
            rbma_pkg::ST_START: ctrl.div_start = 1'b1;
            rbma_pkg::ST_WAIT:  ctrl.load_out  = div_status.done && out_free;
            default:            ctrl = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rbma_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------------
    // Window register and ring bookkeeping. A written window length of zero
    // counts as one, and a length beyond the ring depth counts as the depth.
    // Every write restarts the average from an empty window.
    // ------------------------------------------------------------------------
    always_comb
    begin
        window_next = window_length;
        if (window_length == '0)
        begin
            window_next = CNT_W'(1);
        end
        else if (window_length > CNT_W'(MAX_EFF))
        begin
            window_next = CNT_W'(MAX_EFF);
        end

        full     = filled_reg >= window_reg;
        slot_inc = {1'b0, slot_reg} + 1'b1;
        if ((CNT_W + 1)'(slot_inc) >= (CNT_W + 1)'(window_reg))
        begin
            slot_next = '0;
        end
        else
        begin
            slot_next = slot_inc[SLOT_W-1:0];
        end

        // Once the window is full the overwritten oldest sample leaves the sum.
        oldest     = full ? ring_rd_data : '0;
        delta_next = (SAMPLE_W + 1)'(sample_reg) - (SAMPLE_W + 1)'(oldest);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= CNT_W'(WIN_RST);
            slot_reg   <= '0;
            filled_reg <= '0;
            total_reg  <= '0;
        end
        else if (cfg_valid && ctrl.cfg_ready)
        begin
            window_reg <= window_next;
            slot_reg   <= '0;
            filled_reg <= '0;
            total_reg  <= '0;
        end
        else
        begin
            if (ctrl.ring_wr)
            begin
                slot_reg <= slot_next;
                if (!full)
                begin
                    filled_reg <= filled_reg + 1'b1;
                end
            end
            if (state_reg == rbma_pkg::ST_ADD)
            begin
                total_reg <= total_reg + SUM_W'(delta_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && ctrl.in_ready)
        begin
            sample_reg <= sample;
        end
        if (ctrl.ring_wr)
        begin
            delta_reg <= delta_next;
        end
    end

    rbma_ring #(
        .DEPTH  (MAX_WINDOW),
        .ADDR_W (IDX_W),
        .DATA_W (SAMPLE_W)
    ) u_ring (
        .clk     (clk),
        .rd_en   (ctrl.ring_rd),
        .wr_en   (ctrl.ring_wr),
        .addr    (IDX_W'(slot_reg)),
        .wr_data (sample_reg),
        .rd_data (ring_rd_data)
    );

    // The mean is the running sum over the held count, truncated toward zero.
    rbma_divider #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W),
        .Q_W   (SAMPLE_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .dividend (total_reg),
        .divisor  (filled_reg),
        .status   (div_status),
        .quotient (quotient)
    );

    // ------------------------------------------------------------------------
    // Output register. A finished mean waits here while the sequencer is free
    // to take the next sample; a new mean is loaded only once the previous
    // transaction has gone out.
    // ------------------------------------------------------------------------
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            mean_value_reg <= quotient;
            held_count_reg <= filled_reg;
        end
    end

    assign in_ready   = ctrl.in_ready;
    assign cfg_ready  = ctrl.cfg_ready;
    assign out_valid  = out_valid_reg;
    assign mean_value = mean_value_reg;
    assign held_count = held_count_reg;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    `ASSERT_ALWAYS(a_fill_bound, clk, rst_n, filled_reg <= window_reg)
    `ASSERT_ALWAYS(a_slot_bound, clk, rst_n, (CNT_W + 1)'(slot_reg) < (CNT_W + 1)'(window_reg))
    `ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, out_valid_reg && !out_ready, !ctrl.load_out)
    `ASSERT_IMPLIES(a_div_idle, clk, rst_n, ctrl.div_start, !div_status.busy)
    `ASSERT_NEXT(a_accept_reads, clk, rst_n, in_valid && in_ready, state_reg == rbma_pkg::ST_READ)

endmodule

[dv/tb_ring_buffer_moving_average_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ring_buffer_moving_average_top
// Self-checking bench for the boxcar moving average. Samples are pushed
// through the valid/ready input, each accepted sample updates a local window
// model, and every average leaving the block is compared with the oldest
// predicted one while the window length is changed between batches.
// ----------------------------------------------------------------------------
module tb_ring_buffer_moving_average_top;

    localparam int SAMPLE_W       = rbma_pkg::SAMPLE_W;
    localparam int CNT_W          = rbma_pkg::CNT_W;
    localparam int MAX_WINDOW_DEF = rbma_pkg::MAX_WINDOW_DEF;
    localparam int WIN_RESET      = rbma_pkg::WIN_RESET;

    // Ample settling time after the last average has left the block.
    localparam int DRAIN_CYCLES = 64;
    localparam int LIMIT_CYCLES = 400000;
    localparam int BATCHES      = 12;
    localparam int BATCH_ITEMS  = 130;
    localparam int HOLD_OFF     = 400;

    typedef struct {
        logic signed [SAMPLE_W-1:0] mean;
        logic        [CNT_W-1:0]    count;
    } avg_result_t;

    logic                       clk           = 1'b0;
    logic                       rst_n         = 1'b0;
    logic                       in_valid      = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample        = '0;
    logic                       out_valid;
    logic                       out_ready     = 1'b0;
    logic signed [SAMPLE_W-1:0] mean_value;
    logic        [CNT_W-1:0]    held_count;
    logic                       cfg_valid     = 1'b0;
    logic                       cfg_ready;
    logic        [CNT_W-1:0]    window_length = '0;

    // Samples waiting to be offered, and the averages they are expected to
    // produce, in order.
    logic signed [SAMPLE_W-1:0] sample_queue[$];
    avg_result_t                expected_avgs[$];

    // Window model: ring of held samples, next write slot, count and the
    // exact sum (a longint easily covers sixteen 32-bit samples).
    logic signed [SAMPLE_W-1:0] window_ring[MAX_WINDOW_DEF];
    int                         window_len;
    int                         write_pos;
    int                         held;
    longint                     window_sum;

    int  sender_idle_pct = 0;
    int  recv_idle_pct   = 0;
    int  recv_hold_left  = 0;
    bit  sample_taken    = 1'b0;
    int  cycle_count     = 0;
    int  error_count     = 0;
    int  samples_sent    = 0;
    int  averages_seen   = 0;
    int  window_writes   = 0;

    ring_buffer_moving_average_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .mean_value    (mean_value),
        .held_count    (held_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .window_length (window_length)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A window length write clamps the value into 1..MAX_WINDOW and empties
    // the window, exactly as the block does.
    function automatic void set_window(input logic [CNT_W-1:0] len);
        window_len = int'(len);
        if (window_len == 0)
        begin
            window_len = 1;
        end
        if (window_len > MAX_WINDOW_DEF)
        begin
            window_len = MAX_WINDOW_DEF;
        end
        write_pos  = 0;
        held       = 0;
        window_sum = 0;
    endfunction

    // Push one sample into the window and queue the average it yields. Once
    // the window is full, the sample being overwritten leaves the sum.
    function automatic void push_sample(input logic signed [SAMPLE_W-1:0] s);
        avg_result_t res;
        longint      quot;
        if (write_pos >= window_len)
        begin
            write_pos = 0;
        end
        if (held >= window_len)
        begin
            window_sum -= longint'(window_ring[write_pos]);
        end
        else
        begin
            held++;
        end
        window_ring[write_pos] = s;
        window_sum += longint'(s);
        write_pos++;
        if (write_pos >= window_len)
        begin
            write_pos = 0;
        end
        // Integer division of signed operands truncates toward zero.
        quot      = window_sum / longint'(held);
        res.mean  = SAMPLE_W'(quot);
        res.count = CNT_W'(held);
        expected_avgs.push_back(res);
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Sample driver. A new transaction is only offered once the previous one
    // was taken, so valid and the payload stay put while the block stalls.
    always @(negedge clk)
    begin
        if (!in_valid || sample_taken)
        begin
            if (sample_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                in_valid <= 1'b1;
                sample   <= sample_queue[0];
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        sample_taken = 1'b0;
    end

    // Result receiver. A long hold-off is counted down here; otherwise ready
    // drops at random according to the current idle percentage.
    always @(negedge clk)
    begin
        if (recv_hold_left > 0)
        begin
            out_ready <= 1'b0;
            recv_hold_left--;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: everything is sampled at the rising edge. An accepted sample
    // updates the model at once, which keeps the expected averages in order.
    always @(posedge clk)
    begin
        avg_result_t want;
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("[%0t] timeout after %0d cycles", $time, cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
        else if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                push_sample(sample);
                void'(sample_queue.pop_front());
                sample_taken = 1'b1;
                samples_sent++;
            end
            if (out_valid && out_ready)
            begin
                averages_seen++;
                if (expected_avgs.size() == 0)
                begin
                    report_mismatch("average with none pending", mean_value, 0);
                end
                else
                begin
                    want = expected_avgs.pop_front();
                    if (mean_value !== want.mean)
                    begin
                        report_mismatch("mean_value", mean_value, want.mean);
                    end
                    if (held_count !== want.count)
                    begin
                        report_mismatch("held_count", held_count, want.count);
                    end
                end
            end
        end
    end

    // Wait until every queued sample was taken and every average came back.
    task automatic wait_drained();
        while (sample_queue.size() != 0 || expected_avgs.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Window length writes only happen with the block idle. The model is
    // updated at the edge where the write transaction completes.
    task automatic write_window(input logic [CNT_W-1:0] len);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid     <= 1'b1;
        window_length <= len;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        set_window(len);
        window_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One batch of random samples. Most are full-range words; some are the
    // extremes that stress the wide sum, some are tiny values where the
    // truncation of the mean toward zero shows.
    task automatic queue_random(input int n_items);
        logic signed [SAMPLE_W-1:0] val;
        int                         pick;
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(7);
            if (pick == 0)
            begin
                case ($urandom_range(3))
                    0:       val = 32'sh7FFF_FFFF;
                    1:       val = 32'sh8000_0000;
                    2:       val = 32'sh7FFF_0000;
                    default: val = 32'sh8001_0000;
                endcase
            end
            else if (pick == 1)
            begin
                val = SAMPLE_W'(int'($urandom_range(16)) - 8);
            end
            else
            begin
                val = $urandom;
            end
            sample_queue.push_back(val);
        end
    endtask

    initial
    begin
        logic [CNT_W-1:0] len;
        // The block comes out of reset with a window of 16 and nothing held.
        set_window(CNT_W'(WIN_RESET));
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        sender_idle_pct = 7;
        recv_idle_pct   = 56;

        // Directed part with the reset window: sums past the positive 32-bit
        // range, then small values with negative truncation.
        repeat (3) sample_queue.push_back(32'sh7FFF_FFFF);
        repeat (3) sample_queue.push_back(32'sh8000_0000);
        sample_queue.push_back(-32'sd1);
        sample_queue.push_back(32'sd1);
        sample_queue.push_back(32'sd0);
        sample_queue.push_back(32'sd3);
        sample_queue.push_back(-32'sd7);

        // A window length of zero acts as one: the mean is the sample itself.
        write_window(CNT_W'(0));
        sample_queue.push_back(32'sh8000_0000);
        sample_queue.push_back(32'sh7FFF_FFFF);
        sample_queue.push_back(-32'sd5);
        sample_queue.push_back(32'sd5);

        // A short window wraps quickly, so the oldest sample leaves the sum.
        write_window(CNT_W'(3));
        repeat (4) sample_queue.push_back(32'sh7FFF_FFFF);
        repeat (2) sample_queue.push_back(32'sh8000_0000);

        // Random batches. The window walks through the extremes first,
        // including values above the depth that must saturate, then random
        // lengths. Idling goes from a slow receiver to a slow sender to none.
        for (int b = 0; b < BATCHES; b++)
        begin
            case (b)
                0:       len = CNT_W'(1);
                1:       len = CNT_W'(16);
                2:       len = CNT_W'(31);
                3:       len = CNT_W'(17);
                4:       len = CNT_W'(2);
                5:       len = CNT_W'(15);
                default: len = CNT_W'($urandom_range(31));
            endcase
            write_window(len);
            if (b < 4)
            begin
                sender_idle_pct = 7;
                recv_idle_pct   = 56;
            end
            else if (b < 8)
            begin
                sender_idle_pct = 56;
                recv_idle_pct   = 7;
            end
            else
            begin
                sender_idle_pct = 0;
                recv_idle_pct   = 0;
            end
            queue_random(BATCH_ITEMS);
            // Once, the receiver stalls for a long time while samples keep
            // coming, so the block must hold its result and stop taking input.
            if (b == 1)
            begin
                recv_hold_left = HOLD_OFF;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d samples and %0d averages over %0d window writes,",
                 samples_sent, averages_seen, window_writes);
        $display("with lengths 0 to 31 clamped to 1..16 and both handshakes stalled.");
        if (error_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("%0d mismatches were found", error_count);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
